// ===== rtl/pli_pkg.sv =====
// shared constants and types for the point light irradiance pipeline
package pli_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int NORM_FRAC     = 14;
    localparam int POS_W         = 32;
    localparam int VAL_W         = 31;
    localparam int NRM_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int D2_W          = 64;
    localparam int DIST_W        = 32;
    localparam int DOT_W         = 48;
    localparam int COS_W         = 18;
    localparam int NUM_W         = 35;
    localparam int DEN_W         = 64;
    localparam logic [VAL_W-1:0] OUT_MAX = {VAL_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_X   = 3'd0,
        REG_LIGHT_Y   = 3'd1,
        REG_LIGHT_Z   = 3'd2,
        REG_RANGE     = 3'd3,
        REG_INTENSITY = 3'd4,
        REG_CONST     = 3'd5,
        REG_LINEAR    = 3'd6,
        REG_QUAD      = 3'd7
    } pli_reg_idx_t;

    // per-word flags carried down the pipeline
    typedef struct packed {
        logic far;
        logic kill;
    } pli_flags_t;

endpackage

// ===== rtl/pli_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module pli_sqrt
    import pli_pkg::*;
#(
    parameter int TAG_W = 8
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [D2_W-1:0]   in_x,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [DIST_W-1:0] out_root,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int STAGES = D2_W / 2;

    logic              valid_reg [STAGES];
    logic [D2_W-1:0]   x_reg     [STAGES];
    logic [D2_W-1:0]   r_reg     [STAGES];
    logic [TAG_W-1:0]  tag_reg   [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic             prev_valid;
        logic [D2_W-1:0]  prev_x;
        logic [D2_W-1:0]  prev_r;
        logic [TAG_W-1:0] prev_tag;
        logic [D2_W-1:0]  bit_val;
        logic [D2_W-1:0]  trial;
        logic [D2_W-1:0]  x_next;
        logic [D2_W-1:0]  r_next;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_x     = in_x;
            assign prev_r     = '0;
            assign prev_tag   = in_tag;
        end else begin : g_rest
            assign prev_valid = valid_reg[k-1];
            assign prev_x     = x_reg[k-1];
            assign prev_r     = r_reg[k-1];
            assign prev_tag   = tag_reg[k-1];
        end

        // test one root bit
        assign bit_val = D2_W'(1) << (D2_W - 2 - 2 * k);
        assign trial   = prev_r + bit_val;
        always_comb
        begin
            if (prev_x >= trial)
            begin
                x_next = prev_x - trial;
                r_next = (prev_r >> 1) + bit_val;
            end
            else
            begin
                x_next = prev_x;
                r_next = prev_r >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]   <= x_next;
            r_reg[k]   <= r_next;
            tag_reg[k] <= prev_tag;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = r_reg[STAGES-1][DIST_W-1:0];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ===== rtl/pli_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient known to fit
module pli_div
    import pli_pkg::*;
#(
    parameter int N_W   = 48,
    parameter int D_W   = 32,
    parameter int Q_W   = 18,
    parameter int TAG_W = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [N_W-1:0]   in_num,
    input  logic [D_W-1:0]   in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quot,
    output logic [TAG_W-1:0] out_tag
);

    localparam int CW = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

    logic             valid_reg [Q_W];
    logic [N_W-1:0]   rem_reg   [Q_W];
    logic [D_W-1:0]   den_reg   [Q_W];
    logic [Q_W-1:0]   quot_reg  [Q_W];
    logic [TAG_W-1:0] tag_reg   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             prev_valid;
        logic [N_W-1:0]   prev_rem;
        logic [D_W-1:0]   prev_den;
        logic [Q_W-1:0]   prev_quot;
        logic [TAG_W-1:0] prev_tag;
        logic [CW-1:0]    rem_ext;
        logic [CW-1:0]    den_sh;
        logic             take;
        logic [CW-1:0]    diff;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_num;
            assign prev_den   = in_den;
            assign prev_quot  = '0;
            assign prev_tag   = in_tag;
        end else begin : g_rest
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_den   = den_reg[k-1];
            assign prev_quot  = quot_reg[k-1];
            assign prev_tag   = tag_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign rem_ext = CW'(prev_rem);
        assign den_sh  = CW'(prev_den) << (Q_W - 1 - k);
        assign take    = rem_ext >= den_sh;
        assign diff    = rem_ext - den_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? diff[N_W-1:0] : prev_rem;
            den_reg[k]  <= prev_den;
            quot_reg[k] <= {prev_quot[Q_W-2:0], take};
            tag_reg[k]  <= prev_tag;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];

endmodule

// ===== rtl/point_light_irradiance.sv =====
// top level of the point light irradiance pipeline
//
// A surface point and its normal enter as one word when start is high and
// busy is low. busy stays low: the pipeline takes a new word every cycle.
// Each word leaves as one cycle of done with irradiance and out_of_range.
// The pipeline is built from 3 stages of offset, squares and dot product,
// 32 square root stages, 18 cosine divide stages, 4 stages of attenuation
// products, sums and the overflow test ahead of the final divide, 31 final
// divide stages and the output register. Throughput is one word per cycle.
// Light position, range, intensity and attenuation are written through
// cfg_we, cfg_index and cfg_data while no word is in flight; a write takes
// effect at the next clock edge. Reset empties the pipeline and loads the
// default light (origin, range 10.0, intensity 1.0, constant term 1.0).
// The receiver cannot stall, so results are presented once and never held.
module point_light_irradiance
    import pli_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [POS_W-1:0] point_x,
    input  logic signed [POS_W-1:0] point_y,
    input  logic signed [POS_W-1:0] point_z,
    input  logic signed [NRM_W-1:0] normal_x,
    input  logic signed [NRM_W-1:0] normal_y,
    input  logic signed [NRM_W-1:0] normal_z,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [POS_W-1:0]        cfg_data,
    output logic                    done,
    output logic [VAL_W-1:0]        irradiance,
    output logic                    out_of_range
);

    localparam int L_W   = POS_W + 1;
    localparam int PN_W  = NRM_W + L_W;
    localparam int QP_W  = VAL_W + 64;
    localparam int FN_W  = NUM_W + FRAC_BITS;
    localparam int SQ_TAG_W  = $bits(pli_flags_t) + DOT_W + D2_W;
    localparam int COS_TAG_W = $bits(pli_flags_t) + DIST_W + D2_W;
    localparam int FD_TAG_W  = $bits(pli_flags_t) + 1;
    localparam int CMP_W = DEN_W + VAL_W + 1;

    // configuration registers
    logic [POS_W-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic [VAL_W-1:0] range_reg, intensity_reg, const_reg, linear_reg, quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg   <= '0;
            light_y_reg   <= '0;
            light_z_reg   <= '0;
            range_reg     <= VAL_W'(10) << FRAC_BITS;
            intensity_reg <= VAL_W'(1) << FRAC_BITS;
            const_reg     <= VAL_W'(1) << FRAC_BITS;
            linear_reg    <= '0;
            quad_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pli_reg_idx_t'(cfg_index))
                REG_LIGHT_X:   light_x_reg   <= cfg_data;
                REG_LIGHT_Y:   light_y_reg   <= cfg_data;
                REG_LIGHT_Z:   light_z_reg   <= cfg_data;
                REG_RANGE:     range_reg     <= cfg_data[VAL_W-1:0];
                REG_INTENSITY: intensity_reg <= cfg_data[VAL_W-1:0];
                REG_CONST:     const_reg     <= cfg_data[VAL_W-1:0];
                REG_LINEAR:    linear_reg    <= cfg_data[VAL_W-1:0];
                REG_QUAD:      quad_reg      <= cfg_data[VAL_W-1:0];
                default:       ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: offset toward the light
    logic                  s1_valid_reg;
    logic signed [L_W-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [NRM_W-1:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        lx_reg <= $signed({light_x_reg[POS_W-1], light_x_reg}) - $signed({point_x[POS_W-1], point_x});
        ly_reg <= $signed({light_y_reg[POS_W-1], light_y_reg}) - $signed({point_y[POS_W-1], point_y});
        lz_reg <= $signed({light_z_reg[POS_W-1], light_z_reg}) - $signed({point_z[POS_W-1], point_z});
        nx_reg <= normal_x;
        ny_reg <= normal_y;
        nz_reg <= normal_z;
    end

    // stage 2: magnitudes, squares and normal products
    logic [L_W-1:0] ax, ay, az;
    assign ax = lx_reg[L_W-1] ? L_W'(-lx_reg) : L_W'(lx_reg);
    assign ay = ly_reg[L_W-1] ? L_W'(-ly_reg) : L_W'(ly_reg);
    assign az = lz_reg[L_W-1] ? L_W'(-lz_reg) : L_W'(lz_reg);

    logic                   s2_valid_reg;
    logic                   axis_far_reg;
    logic [D2_W-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [2*VAL_W-1:0]     range2_reg;
    logic signed [PN_W-1:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        axis_far_reg <= (ax > L_W'(range_reg)) || (ay > L_W'(range_reg))
                        || (az > L_W'(range_reg));
        sqx_reg    <= ax[POS_W-1:0] * ax[POS_W-1:0];
        sqy_reg    <= ay[POS_W-1:0] * ay[POS_W-1:0];
        sqz_reg    <= az[POS_W-1:0] * az[POS_W-1:0];
        range2_reg <= range_reg * range_reg;
        px_reg     <= nx_reg * lx_reg;
        py_reg     <= ny_reg * ly_reg;
        pz_reg     <= nz_reg * lz_reg;
    end

    // stage 3: squared distance, dot product and early outs
    logic [D2_W-1:0]          d2_sum;
    logic signed [PN_W+1:0]   dot_sum;
    assign d2_sum  = sqx_reg + sqy_reg + sqz_reg;
    assign dot_sum = (PN_W+2)'(px_reg) + (PN_W+2)'(py_reg) + (PN_W+2)'(pz_reg);

    logic             s3_valid_reg;
    logic [D2_W-1:0]  d2_reg;
    logic [DOT_W-1:0] dot_reg;
    pli_flags_t       s3_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d2_reg  <= d2_sum;
        dot_reg <= dot_sum[DOT_W-1:0];
        s3_flags_reg.far  <= axis_far_reg || (d2_sum > D2_W'(range2_reg));
        s3_flags_reg.kill <= axis_far_reg || (d2_sum > D2_W'(range2_reg))
                             || (d2_sum == '0) || (dot_sum <= 0);
    end

    // distance by square root
    logic                sq_valid;
    logic [DIST_W-1:0]   dist_root;
    logic [SQ_TAG_W-1:0] sq_tag;
    pli_flags_t          sq_flags;
    logic [DOT_W-1:0]    sq_dot;
    logic [D2_W-1:0]     sq_d2;

    pli_sqrt #(
        .TAG_W (SQ_TAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_x      (d2_reg),
        .in_tag    ({s3_flags_reg, dot_reg, d2_reg}),
        .out_valid (sq_valid),
        .out_root  (dist_root),
        .out_tag   (sq_tag)
    );

    assign {sq_flags, sq_dot, sq_d2} = sq_tag;

    // cosine as dot over distance
    logic                 cos_valid;
    logic [COS_W-1:0]     cos14;
    logic [COS_TAG_W-1:0] cos_tag;
    pli_flags_t           cos_flags;
    logic [DIST_W-1:0]    cos_dist;
    logic [D2_W-1:0]      cos_d2;

    pli_div #(
        .N_W   (DOT_W),
        .D_W   (DIST_W),
        .Q_W   (COS_W),
        .TAG_W (COS_TAG_W)
    ) u_cos_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    (sq_dot),
        .in_den    (dist_root),
        .in_tag    ({sq_flags, dist_root, sq_d2}),
        .out_valid (cos_valid),
        .out_quot  (cos14),
        .out_tag   (cos_tag)
    );

    assign {cos_flags, cos_dist, cos_d2} = cos_tag;

    // attenuation and numerator products
    logic                     m_valid_reg;
    pli_flags_t               m_flags_reg;
    logic [VAL_W+COS_W-1:0]   nump_reg;
    logic [VAL_W+DIST_W-1:0]  linp_reg;
    logic [VAL_W+32-1:0]      qlo_reg, qhi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= cos_valid;
    end

    always_ff @(posedge clk)
    begin
        m_flags_reg <= cos_flags;
        nump_reg    <= intensity_reg * cos14;
        linp_reg    <= linear_reg * cos_dist;
        qlo_reg     <= quad_reg * cos_d2[31:0];
        qhi_reg     <= quad_reg * cos_d2[63:32];
    end

    // quadratic term assembly and scaling
    logic [QP_W-1:0] quad_full;
    logic [QP_W-1:0] quad_sh;
    assign quad_full = QP_W'(qlo_reg) + (QP_W'(qhi_reg) << 32);
    assign quad_sh   = quad_full >> (2 * FRAC_BITS);

    logic                     a_valid_reg;
    pli_flags_t               a_flags_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [VAL_W+DIST_W-1:0]  lin_term_reg;
    logic [DEN_W-1:0]         quad_term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        a_flags_reg   <= m_flags_reg;
        num_reg       <= nump_reg[NORM_FRAC +: NUM_W];
        lin_term_reg  <= linp_reg >> FRAC_BITS;
        quad_term_reg <= (|quad_sh[QP_W-1:DEN_W]) ? {DEN_W{1'b1}} : quad_sh[DEN_W-1:0];
    end

    // denominator sum with saturation
    logic [DEN_W+1:0] den_sum;
    assign den_sum = (DEN_W+2)'(const_reg) + (DEN_W+2)'(lin_term_reg)
                     + (DEN_W+2)'(quad_term_reg);

    logic             b_valid_reg;
    pli_flags_t       b_flags_reg;
    logic [NUM_W-1:0] b_num_reg;
    logic [DEN_W-1:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_flags_reg.far  <= a_flags_reg.far;
        b_flags_reg.kill <= a_flags_reg.kill || (num_reg == '0);
        b_num_reg        <= num_reg;
        den_reg          <= (|den_sum[DEN_W+1:DEN_W]) ? {DEN_W{1'b1}} : den_sum[DEN_W-1:0];
    end

    // overflow test ahead of the final divide
    logic [FN_W-1:0]  fnum;
    logic [CMP_W-1:0] fnum_ext;
    logic [CMP_W-1:0] den_lim;
    assign fnum     = FN_W'(b_num_reg) << FRAC_BITS;
    assign fnum_ext = CMP_W'(fnum);
    assign den_lim  = CMP_W'(den_reg) << VAL_W;

    logic             c_valid_reg;
    pli_flags_t       c_flags_reg;
    logic             c_sat_reg;
    logic [FN_W-1:0]  c_num_reg;
    logic [DEN_W-1:0] c_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_flags_reg <= b_flags_reg;
        c_sat_reg   <= fnum_ext >= den_lim;
        c_num_reg   <= fnum;
        c_den_reg   <= den_reg;
    end

    // final divide, skipped lanes get a harmless operand
    logic                f_valid;
    logic [VAL_W-1:0]    f_quot;
    logic [FD_TAG_W-1:0] f_tag;
    pli_flags_t          f_flags;
    logic                f_sat;

    pli_div #(
        .N_W   (FN_W),
        .D_W   (DEN_W),
        .Q_W   (VAL_W),
        .TAG_W (FD_TAG_W)
    ) u_final_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_num    (c_sat_reg ? '0 : c_num_reg),
        .in_den    (c_den_reg),
        .in_tag    ({c_flags_reg, c_sat_reg}),
        .out_valid (f_valid),
        .out_quot  (f_quot),
        .out_tag   (f_tag)
    );

    assign {f_flags, f_sat} = f_tag;

    // output word register
    logic             done_reg;
    logic [VAL_W-1:0] irradiance_reg;
    logic             out_of_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= f_valid;
    end

    always_ff @(posedge clk)
    begin
        out_of_range_reg <= f_flags.far;
        if (f_flags.kill)
            irradiance_reg <= '0;
        else if (f_sat)
            irradiance_reg <= OUT_MAX;
        else
            irradiance_reg <= f_quot;
    end

    assign done         = done_reg;
    assign irradiance   = irradiance_reg;
    assign out_of_range = out_of_range_reg;

endmodule
